>>> src/cne_pkg.sv
package cne_pkg;

    localparam int INDEX_W = 5;
    localparam int VALUE_W = 31;

    typedef logic [INDEX_W-1:0] t_index;
    typedef logic [VALUE_W-1:0] t_value;

endpackage

>>> src/catalan_number_engine_unit.sv
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_stall   i_index_n
// result    out        o_out_valid / i_out_stall o_catalan_value, o_out_of_range
//
// A request for index n of two or more builds the table row by row from row two up to n,
// using the single multiply-accumulate path (table read, multiply, add) that every term passes through.
// Index zero, index one and indices above MAX_INDEX are answered directly, without building the table.
// Reset is synchronous and active low; it clears the sequencer and the output register.
// The block stalls requests while a request is being worked on or its result waits.
module catalan_number_engine_unit #(
    parameter int MAX_INDEX = 19
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [cne_pkg::INDEX_W-1:0] i_index_n,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [cne_pkg::VALUE_W-1:0] o_catalan_value,
    output logic                      o_out_of_range
);

    localparam int DEPTH = MAX_INDEX + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SEED = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]      r_state;
    cne_pkg::t_index r_n;
    cne_pkg::t_index r_row;
    cne_pkg::t_index r_term;
    cne_pkg::t_value r_sum;
    cne_pkg::t_value r_res_val;
    logic            r_res_oor;

    logic            r_s1_vld;
    logic            r_s1_last;
    cne_pkg::t_value r_rd_a;
    cne_pkg::t_value r_rd_b;
    logic            r_s2_vld;
    logic            r_s2_last;
    cne_pkg::t_value r_prod;

    logic            r_out_vld;
    cne_pkg::t_value r_out_val;
    logic            r_out_oor;

    cne_pkg::t_value r_mem [0:DEPTH-1];

    logic            w_accept;
    logic            w_issue;
    logic            w_last;
    logic [AW-1:0]   w_addr_a;
    logic [AW-1:0]   w_addr_b;
    logic            w_wr_en;
    logic [AW-1:0]   w_wr_addr;
    cne_pkg::t_value w_wr_data;
    cne_pkg::t_value n_sum;
    cne_pkg::t_value n_prod;
    logic            w_out_load;

    assign o_in_stall      = (r_state != S_IDLE);
    assign w_accept        = i_in_valid && (r_state == S_IDLE);
    assign w_issue         = (r_state == S_RUN);
    assign w_last          = (r_term == r_row);
    assign w_addr_a        = AW'(r_term - cne_pkg::INDEX_W'(1));
    assign w_addr_b        = AW'(r_row - r_term);
    assign n_sum           = r_sum + r_prod;
    assign n_prod          = r_rd_a * r_rd_b;
    assign w_out_load      = (r_state == S_FIN) && (!r_out_vld || !i_out_stall);
    assign o_out_valid     = r_out_vld;
    assign o_catalan_value = r_out_val;
    assign o_out_of_range  = r_out_oor;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = '0;
        w_wr_data = n_sum;
        if (w_accept && (i_index_n > cne_pkg::INDEX_W'(1))
                && (i_index_n <= cne_pkg::INDEX_W'(MAX_INDEX))) begin
            w_wr_en   = 1'b1;
            w_wr_addr = '0;
            w_wr_data = cne_pkg::VALUE_W'(1);
        end else if (r_state == S_SEED) begin
            w_wr_en   = 1'b1;
            w_wr_addr = AW'(1);
            w_wr_data = cne_pkg::VALUE_W'(1);
        end else if (r_s2_vld && r_s2_last) begin
            w_wr_en   = 1'b1;
            w_wr_addr = AW'(r_row);
            w_wr_data = n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_a <= r_mem[w_addr_a];
        r_rd_b <= r_mem[w_addr_b];
        r_prod <= n_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_n       <= '0;
            r_row     <= '0;
            r_term    <= '0;
            r_sum     <= '0;
            r_res_val <= '0;
            r_res_oor <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s2_last <= 1'b0;
            r_out_vld <= 1'b0;
            r_out_val <= '0;
            r_out_oor <= 1'b0;
        end else begin
            r_s1_vld  <= w_issue;
            r_s1_last <= w_issue && w_last;
            r_s2_vld  <= r_s1_vld;
            r_s2_last <= r_s1_last;

            if (r_s2_vld) begin
                r_sum <= r_s2_last ? '0 : n_sum;
            end

            if (w_out_load) begin
                r_out_vld <= 1'b1;
                r_out_val <= r_res_val;
                r_out_oor <= r_res_oor;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_n <= i_index_n;
                        if (i_index_n > cne_pkg::INDEX_W'(MAX_INDEX)) begin
                            r_res_val <= '0;
                            r_res_oor <= 1'b1;
                            r_state   <= S_FIN;
                        end else if (i_index_n <= cne_pkg::INDEX_W'(1)) begin
                            r_res_val <= cne_pkg::VALUE_W'(1);
                            r_res_oor <= 1'b0;
                            r_state   <= S_FIN;
                        end else begin
                            r_state <= S_SEED;
                        end
                    end
                end
                S_SEED: begin
                    r_row   <= cne_pkg::INDEX_W'(2);
                    r_term  <= cne_pkg::INDEX_W'(1);
                    r_sum   <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (w_last) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_term <= r_term + cne_pkg::INDEX_W'(1);
                    end
                end
                S_WAIT: begin
                    if (r_s2_vld && r_s2_last) begin
                        if (r_row == r_n) begin
                            r_res_val <= n_sum;
                            r_res_oor <= 1'b0;
                            r_state   <= S_FIN;
                        end else begin
                            r_row   <= r_row + cne_pkg::INDEX_W'(1);
                            r_term  <= cne_pkg::INDEX_W'(1);
                            r_state <= S_RUN;
                        end
                    end
                end
                S_FIN: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sim/tb_catalan_number_engine_unit.sv
module tb_catalan_number_engine_unit;

    localparam int MAX_INDEX     = 19;
    localparam int RANDOM_ITEMS  = 800;
    localparam int CALM_TAIL     = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 30;
    localparam int DRAIN_CYCLES  = 300;
    localparam int LIMIT_CYCLES  = 1_000_000;

    typedef struct packed {
        cne_pkg::t_value value;
        logic            oor;
    } t_catalan_result;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_stall;
    cne_pkg::t_index i_index_n;
    logic            o_out_valid;
    logic            i_out_stall;
    cne_pkg::t_value o_catalan_value;
    logic            o_out_of_range;

    cne_pkg::t_index index_queue[$];
    t_catalan_result catalan_expected[$];
    cne_pkg::t_value cat_table[0:MAX_INDEX];
    cne_pkg::t_value row_sum;

    int   total_items;
    int   results_seen;
    int   error_count;
    int   cycle_count;
    int   gap_left;
    int   stall_left;
    int   hold_left;
    logic hold_done;
    logic req_fire;

    catalan_number_engine_unit #(
        .MAX_INDEX(MAX_INDEX)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_index_n      (i_index_n),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_catalan_value(o_catalan_value),
        .o_out_of_range (o_out_of_range)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Rebuilds the table bottom-up for each request, as the block does.
    function automatic t_catalan_result predict_catalan(input cne_pkg::t_index n);
        t_catalan_result r;
        logic [63:0]     prod;
        if (n > MAX_INDEX) begin
            r.value = '0;
            r.oor   = 1'b1;
            return r;
        end
        cat_table[0] = 31'd1;
        cat_table[1] = 31'd1;
        for (int i = 2; i <= n; i++) begin
            row_sum = '0;
            for (int j = 1; j <= i; j++) begin
                prod    = 64'(cat_table[j-1]) * 64'(cat_table[i-j]);
                row_sum = 31'(64'(row_sum) + prod);
            end
            cat_table[i] = row_sum;
        end
        r.value = cat_table[n];
        r.oor   = 1'b0;
        return r;
    endfunction

    function automatic cne_pkg::t_index pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return cne_pkg::t_index'($urandom_range(0, 8));
        end else if (r < 80) begin
            return cne_pkg::t_index'($urandom_range(MAX_INDEX + 1, 31));
        end else if (r < 95) begin
            return cne_pkg::t_index'($urandom_range(9, MAX_INDEX - 2));
        end else begin
            return cne_pkg::t_index'($urandom_range(MAX_INDEX - 1, MAX_INDEX));
        end
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_index_n  <= '0;
            gap_left   = 0;
        end else if (i_in_valid && !req_fire) begin
            i_in_valid <= 1'b1;
        end else if (gap_left > 0) begin
            i_in_valid <= 1'b0;
            gap_left--;
        end else if (index_queue.size() == 0) begin
            i_in_valid <= 1'b0;
        end else if (index_queue.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            gap_left   = $urandom_range(0, 3);
        end else begin
            i_in_valid <= 1'b1;
            i_index_n  <= index_queue.pop_front();
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  = 0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (results_seen < total_items - CALM_TAIL && $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  = $urandom_range(0, 3);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // A long hold-off on the result side fills the block so that it stalls requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen == HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_catalan_result exp_r;
        cycle_count <= cycle_count + 1;
        req_fire    <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            catalan_expected.push_back(predict_catalan(i_index_n));
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (catalan_expected.size() == 0) begin
                $error("unexpected result transfer: catalan_value %0d, out_of_range %0b",
                       o_catalan_value, o_out_of_range);
                error_count++;
            end else begin
                exp_r = catalan_expected.pop_front();
                if (o_catalan_value !== exp_r.value) begin
                    $error("catalan_value: expected %0d, actual %0d",
                           exp_r.value, o_catalan_value);
                    error_count++;
                end
                if (o_out_of_range !== exp_r.oor) begin
                    $error("out_of_range: expected %0b, actual %0b",
                           exp_r.oor, o_out_of_range);
                    error_count++;
                end
            end
        end
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        cne_pkg::t_index directed[$];
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_index_n    = '0;
        i_out_stall  = 1'b0;
        req_fire     = 1'b0;
        results_seen = 0;
        error_count  = 0;
        cycle_count  = 0;
        gap_left     = 0;
        stall_left   = 0;
        hold_left    = 0;
        hold_done    = 1'b0;

        directed = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd0, 5'd1, 5'd10, 5'd15,
                     5'd16, 5'd18, 5'd19, 5'd20, 5'd21, 5'd30, 5'd31, 5'd19, 5'd0,
                     5'd31, 5'd7};
        foreach (directed[k]) begin
            index_queue.push_back(directed[k]);
        end
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            index_queue.push_back(pick_index());
        end
        total_items = index_queue.size();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (index_queue.size() != 0 || i_in_valid || catalan_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && catalan_expected.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
